@@ design/cal_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_pkg: shared types and constants of the cursor array list
// Operation codes, request and result payloads, and the control word that
// the list controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package cal_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int ELEMENT_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int POS_W   = 4;

  // Cell index width wide enough for the largest supported capacity (256).
  localparam int IDX_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INS_BEFORE = 3'd0,
    OP_INS_AFTER  = 3'd1,
    OP_GET        = 3'd2,
    OP_REMOVE     = 3'd3,
    OP_BEGIN      = 3'd4,
    OP_END        = 3'd5,
    OP_NEXT       = 3'd6,
    OP_PRIOR      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] element;
    logic [COUNT_W-1:0] count;
    logic [POS_W-1:0]   position;
    logic               is_empty;
    logic               is_full;
  } res_t;

  // Broadcast to all cells: what to do this cycle, where, and the cursor.
  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] pos;
    logic [IDX_W-1:0] cur;
  } ctl_t;

endpackage

@@ design/cal_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cal_cell: one storage slot of the cursor array list
// Holds one element; takes the new value (at the position) or its left neighbor (above) on insert,
// its right neighbor (position and up) on remove; drives its word onto the read bus when the cursor is here.
// ----------------------------------------------------------------------------
module cal_cell
  import cal_pkg::*;
#(
  parameter int EW  = ELEMENT_BITS_DEF,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  ctl_t          ctl_i,
  input  logic [EW-1:0] val_i,
  input  logic [EW-1:0] left_i,
  input  logic [EW-1:0] right_i,
  output logic [EW-1:0] data_o,
  output logic [EW-1:0] rd_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(IDX);

  logic [EW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.cmd)
      CMD_INSERT: begin
        if (MyIdx == ctl_i.pos) begin
          data_d = val_i;
        end else if (MyIdx > ctl_i.pos) begin
          data_d = left_i;
        end
      end
      CMD_REMOVE: begin
        if (MyIdx >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (MyIdx == ctl_i.cur) ? data_q : '0;

endmodule

@@ design/cursor_array_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cursor_array_list: fixed-capacity ordered list with a cursor
// Controller for count and cursor over a row of shifting storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_i (operation, value) and raise start_i; the
//   transfer happens at the rising edge where start_i is high and busy_o is
//   low. busy_o never rises, so a new command may be issued every cycle.
//   Result channel: res_o is presented for exactly one cycle with valid_o
//   high, in the cycle after the command transfer. The receiver cannot stall.
// Timing:
//   All cells shift in parallel on insert and remove, so the throughput is
//   one command per clock; the result is held in the result register.
// Reset:
//   rst_ni clears the element count, the cursor and the result strobe. The
//   cell contents stay unknown until written; only slots below the count
//   are ever read.
// ----------------------------------------------------------------------------
module cursor_array_list
  import cal_pkg::*;
#(
  parameter int CAPACITY     = CAPACITY_DEF,
  parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  req_t req_i,
  output logic valid_o,
  output res_t res_o
);

  localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapCnt = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] OneCnt = CNT_W'(1);

  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] cursor_q, cursor_d;
  logic             valid_q;
  res_t             res_q, res_d;

  ctl_t                   ctl;
  logic [ELEMENT_BITS-1:0] val;
  logic [ELEMENT_BITS-1:0] data   [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd     [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd_word;

  logic             accept;
  logic             empty, full;
  logic [CNT_W-1:0] cursor_ext;
  logic             ok;
  logic [ELEMENT_BITS-1:0] elem;
  cmd_e             cmd;
  logic [PTR_W-1:0] pos;

  assign busy_o     = 1'b0;
  assign accept     = start_i & ~busy_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CapCnt);
  assign cursor_ext = CNT_W'(cursor_q);
  assign val        = ELEMENT_BITS'(req_i.value);

  // Gather the word under the cursor: only one cell drives nonzero.
  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | rd[k];
    end
  end

  // Decode the command, move count and cursor, pick the cell action.
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    ok       = 1'b0;
    elem     = '0;
    cmd      = CMD_HOLD;
    pos      = cursor_q;
    case (op_e'(req_i.operation))
      OP_INS_BEFORE: begin
        if (!full) begin
          cmd     = CMD_INSERT;
          pos     = cursor_q;
          count_d = count_q + OneCnt;
          ok      = 1'b1;
        end
      end
      OP_INS_AFTER: begin
        if (!full) begin
          cmd      = CMD_INSERT;
          pos      = empty ? '0 : cursor_q + PTR_W'(1);
          cursor_d = pos;
          count_d  = count_q + OneCnt;
          ok       = 1'b1;
        end
      end
      OP_GET: begin
        if (!empty) begin
          elem = rd_word;
          ok   = 1'b1;
        end
      end
      OP_REMOVE: begin
        if (!empty) begin
          elem    = rd_word;
          cmd     = CMD_REMOVE;
          pos     = cursor_q;
          count_d = count_q - OneCnt;
          // Step left when the cursor falls off the new end.
          if (cursor_ext >= count_d && cursor_q != '0) begin
            cursor_d = cursor_q - PTR_W'(1);
          end
          ok = 1'b1;
        end
      end
      OP_BEGIN: begin
        if (!empty) begin
          cursor_d = '0;
          ok       = 1'b1;
        end
      end
      OP_END: begin
        if (!empty) begin
          cursor_d = PTR_W'(count_q - OneCnt);
          ok       = 1'b1;
        end
      end
      OP_NEXT: begin
        if (!empty && (cursor_ext + OneCnt) < count_q) begin
          cursor_d = cursor_q + PTR_W'(1);
          ok       = 1'b1;
        end
      end
      OP_PRIOR: begin
        if (!empty && cursor_q != '0) begin
          cursor_d = cursor_q - PTR_W'(1);
          ok       = 1'b1;
        end
      end
      default: ok = 1'b0;
    endcase

    if (!accept) begin
      cmd      = CMD_HOLD;
      count_d  = count_q;
      cursor_d = cursor_q;
    end

    res_d.ok       = ok;
    res_d.element  = VALUE_W'(elem);
    res_d.count    = COUNT_W'(count_d);
    res_d.position = (count_d == '0) ? '0 : POS_W'(cursor_d);
    res_d.is_empty = (count_d == '0);
    res_d.is_full  = (count_d == CapCnt);
  end

  assign ctl.cmd = cmd;
  assign ctl.pos = IDX_W'(pos);
  assign ctl.cur = IDX_W'(cursor_q);

  // Row of storage cells; neighbors hand words left or right.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ELEMENT_BITS-1:0] left_w, right_w;
    if (k == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = data[k+1];
    end
    cal_cell #(
      .EW  (ELEMENT_BITS),
      .IDX (k)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .val_i   (val),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data[k]),
      .rd_o    (rd[k])
    );
  end

  // Hold list control state; advance on each command transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      cursor_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      count_q  <= count_d;
      cursor_q <= cursor_d;
      valid_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule
